@@ rtl/core/pid_speed_to_torque_defines.svh @@
// assertion macros used by the rtl top level
`ifndef PID_SPEED_TO_TORQUE_DEFINES_SVH
`define PID_SPEED_TO_TORQUE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pst_pkg.sv @@
`timescale 1ns / 1ps
package pst_pkg;

  // widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned PerW   = 17;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 33;
  localparam int unsigned PrdW   = MulAW + MulBW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned AccW   = 51;
  localparam int unsigned MagW   = 20;
  localparam int unsigned QuoW   = 32;
  // dividends stay below 2^51, the estimate uses their top RecipW bits
  localparam int unsigned NumW   = 51;
  localparam int unsigned RecipW = 32;
  localparam int unsigned EstLsb = NumW - RecipW;
  localparam int unsigned ShareW = 16;
  localparam int unsigned ShareShift = 15;

  // fixed point constants
  localparam logic signed [DataW-1:0] StillLimit = 32'sd6;
  localparam logic signed [DataW-1:0] BrakeEmerg = -32'sd144179200;
  localparam logic signed [DataW-1:0] BrakeStill = -32'sd91750400;
  localparam logic signed [AccW-1:0]  AccMax     = 51'sd568852;
  localparam logic signed [AccW-1:0]  DecMaxNeg  = -51'sd767427;
  localparam logic [MagW-1:0]         AccMaxMag  = 20'd568852;
  localparam logic [MagW-1:0]         DecMaxMag  = 20'd767427;

  // reciprocals 2^51 / limit rounded down; both limits exceed 2^19, so the
  // estimate lands at most two below the true quotient
  localparam logic [RecipW-1:0] RecipAcc = RecipW'((64'd1 << NumW) / 64'(AccMaxMag));
  localparam logic [RecipW-1:0] RecipDec = RecipW'((64'd1 << NumW) / 64'(DecMaxMag));

  // reset values of the registers
  localparam logic [CfgW-1:0] GainPropRst     = 31'd65536;
  localparam logic [CfgW-1:0] GainIntRst      = 31'd0;
  localparam logic [CfgW-1:0] GainDerivRst    = 31'd0;
  localparam logic [PerW-1:0] SamplePeriodRst = 17'd655;
  localparam logic [CfgW-1:0] SampleRateRst   = 31'd6553600;
  localparam logic [CfgW-1:0] TorqueLimitRst  = 31'd49152000;

  typedef enum logic [IdxW-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INT      = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_SAMPLE_RATE   = 3'd4,
    REG_TORQUE_LIMIT  = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_INT,
    ST_INT,
    ST_DER,
    ST_PROP,
    ST_INTG,
    ST_DERV,
    ST_CLAMP,
    ST_SH_EST,
    ST_SH_BACK,
    ST_SH_FIX,
    ST_TQ_EST,
    ST_TQ_BACK,
    ST_TQ_FIX,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    MUL_ERR_PERIOD,
    MUL_DIFF_RATE,
    MUL_PROP,
    MUL_INT,
    MUL_DERIV,
    MUL_TORQUE,
    MUL_SH_EST,
    MUL_TQ_EST,
    MUL_BACK
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     int_ld;
    logic     der_ld;
    logic     acc_ld;
    logic     acc_add;
    logic     clamp_ld;
    logic     num_ld;
    logic     est_ld;
    logic     div_torque;
    logic     share_ld;
    logic     torque_ld;
    logic     out_ld;
  } seq_ctrl_t;

  // saturate a wide signed value to 32 bit signed
  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    lo = AccW'(signed'({1'b1, {(DataW-1){1'b0}}}));
    if (x > hi) begin
      return hi[DataW-1:0];
    end else if (x < lo) begin
      return lo[DataW-1:0];
    end
    return x[DataW-1:0];
  endfunction

endpackage

@@ rtl/core/pid_speed_to_torque.sv @@
// sequencing: a regular sample runs through the 13-step schedule on the shared multiplier and
//   then ST_FIN; the emergency and standstill brake cases go straight from ST_IDLE to ST_FIN
// input: a new sample is taken only in ST_IDLE, after the last result has been loaded into
//   the output register; a held result stalls the input
// reset: all configuration registers return to their reset values, integral and last error clear
`timescale 1ns / 1ps
`include "pid_speed_to_torque_defines.svh"
module pid_speed_to_torque (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pst_pkg::IdxW-1:0]           cfg_idx_i,
  input  logic [pst_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [pst_pkg::DataW-1:0]   speed_target_i,
  input  logic signed [pst_pkg::DataW-1:0]   speed_measured_i,
  input  logic                               emergency_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pst_pkg::CfgW-1:0]           engine_drive_o,
  output logic signed [pst_pkg::DataW-1:0]   brake_drive_o,
  output logic [pst_pkg::ShareW-1:0]         throttle_share_o,
  output logic [pst_pkg::ShareW-1:0]         brake_share_o
);
  import pst_pkg::*;

  seq_ctrl_t ctrl;
  state_e    state;

  // configuration registers
  logic [CfgW-1:0] gain_prop_q, gain_int_q, gain_deriv_q;
  logic [PerW-1:0] sample_period_q;
  logic [CfgW-1:0] sample_rate_q, torque_limit_q;

  // controller state and working registers
  logic signed [DataW-1:0] integ_q, last_q, err_q, deriv_q;
  logic signed [AccW-1:0]  acc_q;
  logic [MagW-1:0]         mag_q;
  logic                    neg_q, fixed_q, emerg_q;
  logic [ShareW-1:0]       share_q;
  logic [QuoW-1:0]         torque_q;
  logic [NumW-1:0]         num_q;
  logic [QuoW-1:0]         est_q;

  // output register
  logic                    out_valid_q;
  logic [CfgW-1:0]         engine_q;
  logic signed [DataW-1:0] brake_q;
  logic [ShareW-1:0]       thr_q, brk_q;

  logic                    in_acc, brake_case, out_free;
  logic signed [AccW-1:0]  err_diff, prod_sh, acc_c;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [PrdW-1:0]  prod;
  logic [NumW-1:0]         share_num;
  logic [NumW-1:0]         div_num;
  logic [MagW-1:0]         div_den;
  logic [RecipW-1:0]       div_recip;
  logic [QuoW-1:0]         est_c;
  logic [QuoW-1:0]         div_quo;

  assign in_acc     = in_valid_i & ctrl.in_ready;
  assign brake_case = emergency_i | (speed_target_i <= StillLimit);
  assign out_free   = ~out_valid_q | out_ready_i;

  pst_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .brake_case_i(brake_case),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .state_o     (state)
  );

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q     <= GainPropRst;
      gain_int_q      <= GainIntRst;
      gain_deriv_q    <= GainDerivRst;
      sample_period_q <= SamplePeriodRst;
      sample_rate_q   <= SampleRateRst;
      torque_limit_q  <= TorqueLimitRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GAIN_PROP:     gain_prop_q     <= cfg_wdata_i;
        REG_GAIN_INT:      gain_int_q      <= cfg_wdata_i;
        REG_GAIN_DERIV:    gain_deriv_q    <= cfg_wdata_i;
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata_i[PerW-1:0];
        REG_SAMPLE_RATE:   sample_rate_q   <= cfg_wdata_i;
        REG_TORQUE_LIMIT:  torque_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // division by the clamp limit: share numerator, limit and reciprocal
  assign share_num = NumW'({mag_q, {ShareShift{1'b0}}});
  assign div_num   = ctrl.div_torque ? num_q : share_num;
  assign div_den   = neg_q ? DecMaxMag : AccMaxMag;
  assign div_recip = neg_q ? RecipDec : RecipAcc;
  assign est_c     = prod[2*RecipW-1:RecipW];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MUL_ERR_PERIOD: begin
        mul_a = MulAW'(err_q);
        mul_b = MulBW'(signed'({1'b0, sample_period_q}));
      end
      MUL_DIFF_RATE: begin
        mul_a = MulAW'(err_q) - MulAW'(last_q);
        mul_b = MulBW'(signed'({1'b0, sample_rate_q}));
      end
      MUL_PROP: begin
        mul_a = MulAW'(err_q);
        mul_b = MulBW'(signed'({1'b0, gain_prop_q}));
      end
      MUL_INT: begin
        mul_a = MulAW'(integ_q);
        mul_b = MulBW'(signed'({1'b0, gain_int_q}));
      end
      MUL_DERIV: begin
        mul_a = MulAW'(deriv_q);
        mul_b = MulBW'(signed'({1'b0, gain_deriv_q}));
      end
      MUL_TORQUE: begin
        mul_a = MulAW'(signed'({1'b0, mag_q}));
        mul_b = MulBW'(signed'({1'b0, torque_limit_q}));
      end
      MUL_SH_EST: begin
        mul_a = MulAW'(signed'({1'b0, share_num[NumW-1:EstLsb]}));
        mul_b = MulBW'(signed'({1'b0, div_recip}));
      end
      MUL_TQ_EST: begin
        mul_a = MulAW'(signed'({1'b0, prod[NumW-1:EstLsb]}));
        mul_b = MulBW'(signed'({1'b0, div_recip}));
      end
      MUL_BACK: begin
        mul_a = MulAW'(signed'({1'b0, est_c}));
        mul_b = MulBW'(signed'({1'b0, div_den}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pst_mul u_mul (
    .clk_i(clk_i),
    .en_i (ctrl.mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // product scaled back to Q16.16, arithmetic shift is a floor
  assign prod_sh  = AccW'(signed'(prod[PrdW-1:FracW]));
  assign err_diff = AccW'(speed_target_i) - AccW'(speed_measured_i);

  // acceleration clamped to the vehicle limits
  always_comb begin
    acc_c = acc_q;
    if (acc_q > AccMax) begin
      acc_c = AccMax;
    end else if (acc_q < DecMaxNeg) begin
      acc_c = DecMaxNeg;
    end
  end

  // quotient from the estimate and its back product
  pst_div u_div (
    .num_i (div_num),
    .est_i (est_q),
    .back_i(prod[NumW-1:0]),
    .den_i (div_den),
    .quo_o (div_quo)
  );

  // integral and previous error, cleared on the brake cases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (in_acc && brake_case) begin
      integ_q <= '0;
      last_q  <= '0;
    end else begin
      if (ctrl.int_ld) begin
        integ_q <= sat32(AccW'(integ_q) + prod_sh);
      end
      if (ctrl.der_ld) begin
        last_q <= err_q;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q   <= sat32(err_diff);
      fixed_q <= brake_case;
      emerg_q <= emergency_i;
    end
    if (ctrl.der_ld) begin
      deriv_q <= sat32(prod_sh);
    end
    if (ctrl.acc_ld) begin
      acc_q <= prod_sh;
    end else if (ctrl.acc_add) begin
      acc_q <= acc_q + prod_sh;
    end
    if (ctrl.clamp_ld) begin
      neg_q <= acc_c[AccW-1];
      mag_q <= acc_c[AccW-1] ? MagW'(-acc_c) : MagW'(acc_c);
    end
    if (ctrl.num_ld) begin
      num_q <= prod[NumW-1:0];
    end
    if (ctrl.est_ld) begin
      est_q <= est_c;
    end
    if (ctrl.share_ld) begin
      share_q <= div_quo[ShareW-1:0];
    end
    if (ctrl.torque_ld) begin
      torque_q <= div_quo;
    end
  end

  // result beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      if (fixed_q) begin
        engine_q <= '0;
        brake_q  <= emerg_q ? BrakeEmerg : BrakeStill;
        thr_q    <= '0;
        brk_q    <= '0;
      end else if (neg_q) begin
        engine_q <= '0;
        brake_q  <= -signed'(torque_q);
        thr_q    <= '0;
        brk_q    <= share_q;
      end else begin
        engine_q <= torque_q[CfgW-1:0];
        brake_q  <= '0;
        thr_q    <= share_q;
        brk_q    <= '0;
      end
    end
  end

  assign in_ready_o       = ctrl.in_ready;
  assign out_valid_o      = out_valid_q;
  assign engine_drive_o   = engine_q;
  assign brake_drive_o    = brake_q;
  assign throttle_share_o = thr_q;
  assign brake_share_o    = brk_q;

  // checks
  `PST_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
    "sequencer ready right after an accepted beat")
  `PST_ASSERT_NOW(a_brake_excl, out_valid_o && (brake_drive_o != 0),
    (engine_drive_o == 0) && (throttle_share_o == 0), "brake and engine drive both set")
  `PST_ASSERT_NOW(a_engine_excl, out_valid_o && (engine_drive_o != 0),
    (brake_drive_o == 0) && (brake_share_o == 0), "engine drive with brake output")
  `PST_ASSERT_NOW(a_div_range, (state == ST_SH_FIX) || (state == ST_TQ_FIX),
    div_num >= prod[NumW-1:0], "quotient estimate above the true quotient")

endmodule

@@ rtl/core/pst_mul.sv @@
`timescale 1ns / 1ps
module pst_mul (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [pst_pkg::MulAW-1:0] a_i,
  input  logic signed [pst_pkg::MulBW-1:0] b_i,
  output logic signed [pst_pkg::PrdW-1:0]  p_o
);
  import pst_pkg::*;

  logic signed [PrdW-1:0] p_q;

  // shared signed multiplier, product held until the next issue
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PrdW'(a_i) * PrdW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/pst_div.sv @@
`timescale 1ns / 1ps
module pst_div (
  input  logic [pst_pkg::NumW-1:0]   num_i,
  input  logic [pst_pkg::QuoW-1:0]   est_i,
  input  logic [pst_pkg::NumW-1:0]   back_i,
  input  logic [pst_pkg::MagW-1:0]   den_i,
  output logic [pst_pkg::QuoW-1:0]   quo_o
);
  import pst_pkg::*;

  logic [NumW-1:0] rem;

  // remainder left by the reciprocal estimate, below three divisors
  assign rem = num_i - back_i;

  // step the estimate up by the divisors still left in the remainder
  always_comb begin
    quo_o = est_i;
    if (rem >= NumW'({den_i, 1'b0})) begin
      quo_o = est_i + QuoW'(2);
    end else if (rem >= NumW'(den_i)) begin
      quo_o = est_i + QuoW'(1);
    end
  end

endmodule

@@ rtl/core/pst_seq.sv @@
`timescale 1ns / 1ps
module pst_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               brake_case_i,
  input  logic               out_free_i,
  output pst_pkg::seq_ctrl_t ctrl_o,
  output pst_pkg::state_e    state_o
);
  import pst_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = brake_case_i ? ST_FIN : ST_MUL_INT;
        end
      end
      ST_MUL_INT: state_d = ST_INT;
      ST_INT:     state_d = ST_DER;
      ST_DER:     state_d = ST_PROP;
      ST_PROP:    state_d = ST_INTG;
      ST_INTG:    state_d = ST_DERV;
      ST_DERV:    state_d = ST_CLAMP;
      ST_CLAMP:   state_d = ST_SH_EST;
      ST_SH_EST:  state_d = ST_SH_BACK;
      ST_SH_BACK: state_d = ST_SH_FIX;
      ST_SH_FIX:  state_d = ST_TQ_EST;
      ST_TQ_EST:  state_d = ST_TQ_BACK;
      ST_TQ_BACK: state_d = ST_TQ_FIX;
      ST_TQ_FIX:  state_d = ST_FIN;
      ST_FIN: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_MUL_INT: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_ERR_PERIOD;
      end
      ST_INT: begin
        ctrl_o.int_ld  = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_DIFF_RATE;
      end
      ST_DER: begin
        ctrl_o.der_ld  = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_PROP;
      end
      ST_PROP: begin
        ctrl_o.acc_ld  = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_INT;
      end
      ST_INTG: begin
        ctrl_o.acc_add = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_DERIV;
      end
      ST_DERV:  ctrl_o.acc_add  = 1'b1;
      ST_CLAMP: ctrl_o.clamp_ld = 1'b1;
      ST_SH_EST: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_SH_EST;
      end
      ST_SH_BACK: begin
        ctrl_o.est_ld  = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_BACK;
      end
      ST_SH_FIX: begin
        ctrl_o.share_ld = 1'b1;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_sel  = MUL_TORQUE;
      end
      ST_TQ_EST: begin
        ctrl_o.num_ld     = 1'b1;
        ctrl_o.div_torque = 1'b1;
        ctrl_o.mul_en     = 1'b1;
        ctrl_o.mul_sel    = MUL_TQ_EST;
      end
      ST_TQ_BACK: begin
        ctrl_o.est_ld     = 1'b1;
        ctrl_o.div_torque = 1'b1;
        ctrl_o.mul_en     = 1'b1;
        ctrl_o.mul_sel    = MUL_BACK;
      end
      ST_TQ_FIX: begin
        ctrl_o.torque_ld  = 1'b1;
        ctrl_o.div_torque = 1'b1;
      end
      ST_FIN:  ctrl_o.out_ld = out_free_i;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

@@ verif/pst_torque_checker.sv @@
`timescale 1ns / 1ps
module pst_torque_checker
  import pst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IdxW-1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [DataW-1:0] speed_target_i,
  input  logic signed [DataW-1:0] speed_measured_i,
  input  logic                    emergency_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [CfgW-1:0]         engine_drive_i,
  input  logic signed [DataW-1:0] brake_drive_i,
  input  logic [ShareW-1:0]       throttle_share_i,
  input  logic [ShareW-1:0]       brake_share_i,
  output int unsigned             fail_cnt_o,
  output int unsigned             pending_o
);

  localparam int unsigned MaxReports = 10;
  localparam longint S32Max   = 64'sd2147483647;
  localparam longint S32Min   = -64'sd2147483648;
  localparam longint AccTop   = longint'(AccMaxMag);
  localparam longint DecTop   = longint'(DecMaxMag);
  localparam longint ShareOne = 64'sd1 << ShareShift;

  typedef struct packed {
    logic [CfgW-1:0]   engine;
    logic [DataW-1:0]  brake;
    logic [ShareW-1:0] throttle;
    logic [ShareW-1:0] brake_sh;
  } torque_cmd_t;

  // shadow copy of the registers
  longint k_prop, k_int, k_der, dt_q16, rate_q16, torque_max;
  // controller memory
  longint integ_q, err_prev;

  torque_cmd_t torque_expected[$];

  function automatic longint clip_s32(input longint x);
    if (x > S32Max) return S32Max;
    if (x < S32Min) return S32Min;
    return x;
  endfunction

  // one control step: brake cases or pid, then clamp and scaling
  function automatic torque_cmd_t predict_torque(input longint tgt, input longint meas,
                                                 input logic emerg);
    torque_cmd_t cmd;
    longint err, deriv, acc, mag, engine, brake, thr, brk;
    engine = 0;
    brake  = 0;
    thr    = 0;
    brk    = 0;
    if (emerg || tgt <= longint'(StillLimit)) begin
      brake    = emerg ? longint'(BrakeEmerg) : longint'(BrakeStill);
      integ_q  = 0;
      err_prev = 0;
    end else begin
      err      = clip_s32(tgt - meas);
      integ_q  = clip_s32(integ_q + ((err * dt_q16) >>> FracW));
      deriv    = clip_s32(((err - err_prev) * rate_q16) >>> FracW);
      err_prev = err;
      acc = ((k_prop * err) >>> FracW) + ((k_int * integ_q) >>> FracW)
          + ((k_der * deriv) >>> FracW);
      if (acc > AccTop) acc = AccTop;
      if (acc < -DecTop) acc = -DecTop;
      // zero acceleration takes the throttle side
      if (acc >= 0) begin
        thr    = (acc * ShareOne) / AccTop;
        engine = (acc * torque_max) / AccTop;
      end else begin
        mag   = -acc;
        brk   = (mag * ShareOne) / DecTop;
        brake = -((mag * torque_max) / DecTop);
      end
    end
    cmd.engine   = CfgW'(engine);
    cmd.brake    = DataW'(brake);
    cmd.throttle = ShareW'(thr);
    cmd.brake_sh = ShareW'(brk);
    return cmd;
  endfunction

  task automatic flag_failure(input string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= MaxReports) $display("%0t ns: %s", $time, msg);
  endtask

  // track registers, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    torque_cmd_t got;
    torque_cmd_t want;
    if (!rst_ni) begin
      k_prop     = longint'(GainPropRst);
      k_int      = longint'(GainIntRst);
      k_der      = longint'(GainDerivRst);
      dt_q16     = longint'(SamplePeriodRst);
      rate_q16   = longint'(SampleRateRst);
      torque_max = longint'(TorqueLimitRst);
      integ_q    = 0;
      err_prev   = 0;
      torque_expected.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_PROP:     k_prop = longint'(cfg_wdata_i);
          REG_GAIN_INT:      k_int = longint'(cfg_wdata_i);
          REG_GAIN_DERIV:    k_der = longint'(cfg_wdata_i);
          REG_SAMPLE_PERIOD: dt_q16 = longint'(cfg_wdata_i[PerW-1:0]);
          REG_SAMPLE_RATE:   rate_q16 = longint'(cfg_wdata_i);
          REG_TORQUE_LIMIT:  torque_max = longint'(cfg_wdata_i);
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        torque_expected.push_back(predict_torque(speed_target_i, speed_measured_i,
                                                 emergency_i));
      end

      if (out_valid_i && out_ready_i) begin
        got = {engine_drive_i, brake_drive_i, throttle_share_i, brake_share_i};
        if (torque_expected.size() == 0) begin
          flag_failure($sformatf("result beat with no sample pending: engine %0d brake %0d thr %0d brk %0d",
                                 got.engine, $signed(got.brake), got.throttle, got.brake_sh));
        end else begin
          want = torque_expected.pop_front();
          if (got !== want) begin
            flag_failure($sformatf({"torque mismatch: expected engine %0d brake %0d thr %0d",
                                    " brk %0d, got engine %0d brake %0d thr %0d brk %0d"},
                                   want.engine, $signed(want.brake), want.throttle,
                                   want.brake_sh, got.engine, $signed(got.brake),
                                   got.throttle, got.brake_sh));
          end
        end
      end
    end
    pending_o = torque_expected.size();
  end

endmodule

@@ verif/tb_pid_speed_to_torque.sv @@
`timescale 1ns / 1ps
module tb_pid_speed_to_torque;
  import pst_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned PhaseItems  = 210;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned HoldCycles  = 800;
  localparam int unsigned TailCycles  = 100;
  localparam int          CruiseNoise = 6000;
  localparam int unsigned SendIdle[4]  = '{0, 74, 0, 8};
  localparam int unsigned RecvStall[4] = '{0, 0, 74, 8};
  localparam logic signed [DataW-1:0] SpeedMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] SpeedMin = 32'sh8000_0000;

  typedef enum {
    SET_TOP,
    SET_ZERO,
    SET_TYPICAL,
    SET_RANDOM,
    SET_INTEG_SAT,
    SET_DERIV_SAT
  } cfg_set_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [IdxW-1:0]         cfg_idx_i;
  logic [CfgW-1:0]         cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [DataW-1:0] speed_target_i;
  logic signed [DataW-1:0] speed_measured_i;
  logic                    emergency_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [CfgW-1:0]         engine_drive_o;
  logic signed [DataW-1:0] brake_drive_o;
  logic [ShareW-1:0]       throttle_share_o;
  logic [ShareW-1:0]       brake_share_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int          cruise_target;
  int          cruise_speed;

  pid_speed_to_torque i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .speed_target_i   (speed_target_i),
    .speed_measured_i (speed_measured_i),
    .emergency_i      (emergency_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .engine_drive_o   (engine_drive_o),
    .brake_drive_o    (brake_drive_o),
    .throttle_share_o (throttle_share_o),
    .brake_share_o    (brake_share_o)
  );

  pst_torque_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .speed_target_i   (speed_target_i),
    .speed_measured_i (speed_measured_i),
    .emergency_i      (emergency_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .engine_drive_i   (engine_drive_o),
    .brake_drive_i    (brake_drive_o),
    .throttle_share_i (throttle_share_o),
    .brake_share_i    (brake_share_o),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending_cnt)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls plus a single long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgW-1:0] pick_gain();
    return ($urandom_range(3) == 0) ? CfgW'($urandom) : CfgW'($urandom_range(0, 4 << FracW));
  endfunction

  // write all registers; only called with nothing in flight
  task automatic program_setting(input cfg_set_e kind);
    logic [CfgW-1:0] prop, integ, deriv, period, rate, limit;
    prop   = CfgW'(1 << FracW);
    integ  = '0;
    deriv  = '0;
    period = CfgW'(SamplePeriodRst);
    rate   = SampleRateRst;
    limit  = TorqueLimitRst;
    case (kind)
      SET_TOP: begin
        prop   = '1;
        integ  = '1;
        deriv  = '1;
        period = '1;
        rate   = '1;
        limit  = '1;
      end
      SET_ZERO: begin
        prop   = '0;
        period = '0;
        rate   = '0;
        limit  = '0;
      end
      SET_TYPICAL: begin
        prop  = CfgW'(2 << FracW);
        integ = CfgW'(1 << (FracW - 1));
        deriv = CfgW'(3277);
        limit = CfgW'(750 << FracW);
      end
      SET_INTEG_SAT: begin
        prop   = '0;
        integ  = CfgW'(1);
        period = CfgW'(1 << FracW);
      end
      SET_DERIV_SAT: begin
        prop  = '0;
        deriv = CfgW'(1);
        rate  = '1;
      end
      default: begin
        prop   = pick_gain();
        integ  = pick_gain();
        deriv  = pick_gain();
        period = ($urandom_range(3) == 0) ? CfgW'($urandom) : CfgW'($urandom_range(1, 1 << FracW));
        rate   = ($urandom_range(3) == 0) ? CfgW'($urandom)
                                          : CfgW'($urandom_range(1 << FracW, 200 << FracW));
        limit  = ($urandom_range(3) == 0) ? CfgW'($urandom) : CfgW'($urandom_range(0, 2000 << FracW));
      end
    endcase
    write_reg(REG_GAIN_PROP, prop);
    write_reg(REG_GAIN_INT, integ);
    write_reg(REG_GAIN_DERIV, deriv);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_TORQUE_LIMIT, limit);
    // unused indexes must leave every register alone
    if (kind == SET_TOP) begin
      for (int i = REG_TORQUE_LIMIT + 1; i < (1 << IdxW); i++) begin
        write_reg(IdxW'(i), CfgW'($urandom));
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // offer one sample beat, with an optional idle gap first
  task automatic send_sample(input logic signed [DataW-1:0] target,
                             input logic signed [DataW-1:0] measured, input logic emerg);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
      in_valid_i       <= 1'b0;
      speed_target_i   <= $urandom;
      speed_measured_i <= $urandom;
      emergency_i      <= $urandom_range(1);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    speed_target_i   <= target;
    speed_measured_i <= measured;
    emergency_i      <= emerg;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and wait for every pending result
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  // one random sample: mostly a smooth speed trace, some brake cases and noise
  task automatic send_random_sample();
    logic signed [DataW-1:0] target, measured;
    logic emerg;
    int unsigned sel;
    sel   = $urandom_range(99);
    emerg = 1'b0;
    if (sel < 5) begin
      emerg    = 1'b1;
      target   = $urandom;
      measured = $urandom;
    end else if (sel < 11) begin
      target   = ($urandom_range(1) == 0) ? DataW'(StillLimit - $urandom_range(0, 8))
                                          : ($urandom | 32'h8000_0000);
      measured = $urandom;
    end else if (sel < 19) begin
      target   = $urandom;
      measured = $urandom;
    end else begin
      if ($urandom_range(9) == 0) cruise_target = $urandom_range(7, 45 << FracW);
      cruise_speed = cruise_speed + (cruise_target - cruise_speed) / 8
                   + int'($urandom_range(0, 2 * CruiseNoise)) - CruiseNoise;
      target   = cruise_target;
      measured = cruise_speed;
    end
    send_sample(target, measured, emerg);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    speed_target_i   = '0;
    speed_measured_i = '0;
    emergency_i      = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_left        = 0;
    cycle_cnt        = 0;
    cruise_target    = 20 << FracW;
    cruise_speed     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset gains: brake cases, clamp edges, error saturation
    send_sample(SpeedMax, SpeedMin, 1'b1);
    send_sample(SpeedMin, 32'sd0, 1'b1);
    send_sample(StillLimit, 32'sd0, 1'b0);
    send_sample(SpeedMin, SpeedMax, 1'b0);
    send_sample(32'sd7, 32'sd7, 1'b0);
    send_sample(32'sd7, 32'sd6, 1'b0);
    send_sample(32'sd1000000, 32'sd1000000 - int'(AccMaxMag), 1'b0);
    send_sample(32'sd1000000, 32'sd1000000 - int'(AccMaxMag) - 1, 1'b0);
    send_sample(32'sd1000000, 32'sd1000000 + int'(DecMaxMag), 1'b0);
    send_sample(32'sd1000000, 32'sd1000000 + int'(DecMaxMag) + 1, 1'b0);
    send_sample(SpeedMax, SpeedMin, 1'b0);
    send_sample(32'sd7, SpeedMax, 1'b0);
    send_sample(32'sd100 << FracW, 32'sd99 << FracW, 1'b0);
    send_sample(32'sd50 << FracW, 32'sd0, 1'b1);
    send_sample(32'sd5 << FracW, 32'sd0, 1'b0);
    wait_results_drained();

    // integral running into both rails
    program_setting(SET_INTEG_SAT);
    send_sample(SpeedMax, 32'sd0, 1'b0);
    send_sample(SpeedMax, 32'sd0, 1'b0);
    send_sample(32'sd7, SpeedMax, 1'b0);
    send_sample(32'sd7, SpeedMax, 1'b0);
    send_sample(32'sd7, SpeedMax, 1'b0);
    wait_results_drained();

    // derivative running into both rails, then a flat step
    program_setting(SET_DERIV_SAT);
    send_sample(SpeedMax, 32'sd0, 1'b0);
    send_sample(32'sd7, SpeedMax, 1'b0);
    send_sample(32'sd1000, 32'sd990, 1'b0);
    send_sample(32'sd1000, 32'sd990, 1'b0);
    wait_results_drained();

    // random phases over settings and idle patterns
    for (int unsigned p = 0; p < RandPhases; p++) begin
      program_setting((p == 1) ? SET_TOP :
                      (p == 2) ? SET_ZERO :
                      (p == 0 || p == 4) ? SET_TYPICAL : SET_RANDOM);
      send_idle_pct  = SendIdle[p % 4];
      recv_stall_pct = RecvStall[p % 4];
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        // long hold-off on the result side while beats keep coming
        if (p == 0 && i == 40) hold_left = HoldCycles;
        if (i == PhaseItems / 2) wait_results_drained();
        send_random_sample();
      end
      wait_results_drained();
    end

    recv_stall_pct = 0;
    repeat (TailCycles) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
